// ===== rtl/rlmc_pkg.sv =====
`default_nettype none

package rlmc_pkg;

	localparam int unsigned FieldWidth    = 16;
	localparam int unsigned ValueWidthDef = 16;
	localparam int unsigned AddrWidth     = 4;
	localparam int unsigned LetterA       = 65;
	localparam int unsigned AlphaCount    = 26;

	localparam logic [FieldWidth-1:0] PubExpReset  = 16'd7;
	localparam logic [FieldWidth-1:0] PrivExpReset = 16'd103;
	localparam logic [FieldWidth-1:0] ModulusReset = 16'd143;

	typedef enum logic [1:0] {
		REG_PUB_EXP  = 2'd0,
		REG_PRIV_EXP = 2'd1,
		REG_MODULUS  = 2'd2
	} reg_idx_t;

	typedef enum logic {
		OP_ENCRYPT = 1'b0,
		OP_DECRYPT = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [FieldWidth-1:0] public_exponent;
		logic [FieldWidth-1:0] private_exponent;
		logic [FieldWidth-1:0] modulus;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED,
		ST_STEP,
		ST_MUL,
		ST_SQR,
		ST_FIN
	} state_t;

endpackage

`default_nettype wire

// ===== rtl/rlmc_regs.sv =====
`default_nettype none

module rlmc_regs
	import rlmc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [AddrWidth-1:0] paddr,
	input  wire logic [31:0]          pwdata,
	output logic      [31:0]          prdata,
	output logic                      pready,
	output cfg_t                      cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.public_exponent  <= PubExpReset;
			cfg_q.private_exponent <= PrivExpReset;
			cfg_q.modulus          <= ModulusReset;
		end else if (wr_en) begin
			case (idx)
				REG_PUB_EXP:  cfg_q.public_exponent  <= pwdata[FieldWidth-1:0];
				REG_PRIV_EXP: cfg_q.private_exponent <= pwdata[FieldWidth-1:0];
				REG_MODULUS:  cfg_q.modulus          <= pwdata[FieldWidth-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_PUB_EXP:  prdata = 32'(cfg_q.public_exponent);
			REG_PRIV_EXP: prdata = 32'(cfg_q.private_exponent);
			REG_MODULUS:  prdata = 32'(cfg_q.modulus);
			default:      prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/rlmc_modmul.sv =====
`default_nettype none

// Interleaved modular multiplier: one multiplier bit per cycle, MSB first.
// Requires a < m; the product a*b mod m appears on p with the done pulse.
module rlmc_modmul
	import rlmc_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [VALUE_WIDTH-1:0] a,
	input  wire logic [VALUE_WIDTH-1:0] b,
	input  wire logic [VALUE_WIDTH-1:0] m,
	output logic                        done,
	output logic      [VALUE_WIDTH-1:0] p
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned CW = (W > 1) ? $clog2(W) : 1;

	logic [W-1:0]  r_q;
	logic [W-1:0]  a_q;
	logic [W-1:0]  b_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;

	logic [W:0]   dbl;
	logic [W:0]   dbl_red;
	logic [W:0]   sum;
	logic [W:0]   sum_red;
	logic [W:0]   m_ext;

	always_comb begin
		m_ext   = {1'b0, m};
		dbl     = {r_q, 1'b0};
		dbl_red = (dbl >= m_ext) ? dbl - m_ext : dbl;
		sum     = {1'b0, dbl_red[W-1:0]} + (b_q[W-1] ? {1'b0, a_q} : '0);
		sum_red = (sum >= m_ext) ? sum - m_ext : sum;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q <= '0;
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			r_q <= sum_red[W-1:0];
			b_q <= b_q << 1;
		end
	end

	assign done = done_q;
	assign p    = r_q;

endmodule

`default_nettype wire

// ===== rtl/rsa_letter_modexp_cipher.sv =====
`default_nettype none

// An item costs one base reduction, then per exponent bit up to the top set bit a step,
// a squaring and a product when the bit is set. Bad letters and a zero modulus skip
// straight to the finishing state. One item at a time; busy gates start.
// The result is shown for one cycle with done; the receiver cannot stall it.
// Reset (arst_n low, asynchronous) returns to idle and loads exponents 7, 103, modulus 143.
module rsa_letter_modexp_cipher
	import rlmc_pkg::*;
#(
	parameter int unsigned VALUE_WIDTH = ValueWidthDef
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [AddrWidth-1:0]  paddr,
	input  wire logic [31:0]           pwdata,
	output logic      [31:0]           prdata,
	output logic                       pready,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  opcode,
	input  wire logic [FieldWidth-1:0] data_in,
	input  wire logic                  last_in,
	output logic                       done,
	output logic      [FieldWidth-1:0] data_out,
	output logic                       bad_letter,
	output logic                       last_out
);

	localparam int unsigned W = VALUE_WIDTH;

	cfg_t   cfg;
	state_t state_q, state_d;

	logic          op_q;
	logic          last_q;
	logic          bad_q;
	logic [W-1:0]  acc_q;
	logic [W-1:0]  base_q;
	logic [W-1:0]  exp_q;
	logic [W-1:0]  m_q;

	logic [FieldWidth-1:0] data_out_q;
	logic                  bad_letter_q;
	logic                  last_out_q;
	logic                  done_q;

	logic [W-1:0]  data_w;
	logic [W-1:0]  m_w;
	logic [W-1:0]  one_w;
	logic [W-1:0]  base_in;
	logic          is_letter;
	logic          reject;
	logic          accept;

	logic          mm_start;
	logic [W-1:0]  mm_a;
	logic [W-1:0]  mm_b;
	logic          mm_done;
	logic [W-1:0]  mm_p;

	rlmc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rlmc_modmul #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_modmul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.m      (m_q),
		.done   (mm_done),
		.p      (mm_p)
	);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	assign data_w    = W'(data_in);
	assign m_w       = W'(cfg.modulus);
	assign one_w     = (m_w == W'(1)) ? '0 : W'(1);
	assign is_letter = (data_w >= W'(LetterA)) && (data_w < W'(LetterA + AlphaCount));
	assign base_in   = (opcode == OP_DECRYPT) ? data_w : data_w - W'(LetterA);
	// A non-letter to encrypt or a zero modulus needs no exponentiation at all.
	assign reject    = ((opcode == OP_ENCRYPT) && !is_letter) || (m_w == '0);

	always_comb begin
		state_d  = state_q;
		mm_start = 1'b0;
		mm_a     = base_q;
		mm_b     = base_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (reject) begin
						state_d = ST_FIN;
					end else begin
						// Reduce the base by multiplying it with 1 mod m.
						mm_start = 1'b1;
						mm_a     = one_w;
						mm_b     = base_in;
						state_d  = ST_RED;
					end
				end
			end
			ST_RED: begin
				if (mm_done) begin
					state_d = ST_STEP;
				end
			end
			ST_STEP: begin
				if (exp_q == '0) begin
					state_d = ST_FIN;
				end else if (exp_q[0]) begin
					mm_start = 1'b1;
					mm_a     = acc_q;
					mm_b     = base_q;
					state_d  = ST_MUL;
				end else begin
					mm_start = 1'b1;
					state_d  = ST_SQR;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					mm_start = 1'b1;
					state_d  = ST_SQR;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					state_d = ST_STEP;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					op_q   <= opcode;
					last_q <= last_in;
					bad_q  <= (opcode == OP_ENCRYPT) && !is_letter;
					m_q    <= m_w;
					acc_q  <= reject ? '0 : one_w;
					exp_q  <= (opcode == OP_DECRYPT) ? W'(cfg.private_exponent)
					                                 : W'(cfg.public_exponent);
				end
			end
			ST_RED: begin
				if (mm_done) begin
					base_q <= mm_p;
				end
			end
			ST_MUL: begin
				if (mm_done) begin
					acc_q <= mm_p;
				end
			end
			ST_SQR: begin
				if (mm_done) begin
					base_q <= mm_p;
					exp_q  <= exp_q >> 1;
				end
			end
			ST_FIN: begin
				if (op_q == OP_DECRYPT) begin
					data_out_q <= {8'd0, acc_q[7:0] + 8'(LetterA)};
				end else begin
					data_out_q <= FieldWidth'(acc_q);
				end
				bad_letter_q <= bad_q;
				last_out_q   <= last_q;
			end
			default: ;
		endcase
	end

	assign done       = done_q;
	assign data_out   = data_out_q;
	assign bad_letter = bad_letter_q;
	assign last_out   = last_out_q;

`ifndef NO_ASSERTIONS
	a_mm_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		mm_done |-> (state_q == ST_RED || state_q == ST_MUL || state_q == ST_SQR))
		else $error("multiplier finished outside an arithmetic state");

	a_done_after_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(state_q == ST_FIN))
		else $error("result strobe without a finishing state");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not make the block busy");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && bad_letter_q) |-> (data_out_q == '0))
		else $error("bad letter result carries nonzero data");
`endif

endmodule

`default_nettype wire
